@@ sv/afps_pkg.sv @@
// Shared types and constants for the array fill and point write sum block.
package afps_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int VALUE_BITS  = 30;
   localparam int INDEX_BITS  = $clog2(MAX_ENTRIES);
   localparam int COUNT_BITS  = 11;
   localparam int TOTAL_BITS  = 41;
   localparam int SUM_BITS    = 40;
   localparam int EPOCH_BITS  = 8;

   // Queue between front and back; depth must be a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1024);
   localparam logic [COUNT_BITS-1:0] COUNT_CAP   = COUNT_BITS'(MAX_ENTRIES);
   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
   localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = {EPOCH_BITS{1'b1}};
   localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;
   localparam logic [INDEX_BITS-1:0] INDEX_LAST  = INDEX_BITS'(MAX_ENTRIES - 1);

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_FILL  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [INDEX_BITS-1:0]   idx;
      logic [VALUE_BITS-1:0]   val;
      logic                    err;
      logic [COUNT_BITS-1:0]   cnt;
   } queue_item_type;

   typedef struct packed {
      logic [EPOCH_BITS-1:0] tag;
      logic [VALUE_BITS-1:0] value;
   } mem_entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CALC,
      BK_COMMIT,
      BK_CLEAR
   } back_state_type;

endpackage

@@ sv/array_fill_and_point_write_sum_top.sv @@
// Top level: table with lazy global fill and running sum of entries.
// Each transaction goes through the back-end steps pop and memory read, sum and commit; the
// back end starts the next one only after the commit, and the commit waits while a held
// response is stalled. Meanwhile the front keeps accepting transactions until the queue is full.
// Reset (synchronous, active high) starts a tag clearing pass over every entry; no transaction is
// processed until it ends. Every 255th fill wraps the epoch and runs the same clearing pass.
// The element count register resets to 1024 and may be written at any cycle the block is idle.
module array_fill_and_point_write_sum_top
   import afps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_write_enable,
   input  logic [COUNT_BITS-1:0] csr_write_data,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [INDEX_BITS-1:0] req_entry_index,
   input  logic [VALUE_BITS-1:0] req_new_value,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SUM_BITS-1:0]   rsp_total_sum,
   output logic                  rsp_index_error
);

   // Front classifies each transaction (fill or point write, index range check)
   // and pushes it into the queue; back drains the queue one transaction at a time.
   logic           q_push;
   queue_item_type q_push_item;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;
   queue_item_type q_head_item;

   afps_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_entry_index  (req_entry_index),
      .req_new_value    (req_new_value),
      .queue_full       (q_full),
      .push             (q_push),
      .push_item        (q_push_item)
   );

   // Decouple accept from execution so the front keeps taking transactions
   // while the back waits on a stalled response.
   afps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_item (q_head_item)
   );

   // Back holds the entry memory with epoch tags: a fill bumps the epoch instead
   // of touching every entry, so stale entries read back as the fill value.
   afps_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (q_empty),
      .head_item       (q_head_item),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_total_sum   (rsp_total_sum),
      .rsp_index_error (rsp_index_error)
   );

endmodule

@@ sv/afps_front.sv @@
// Front end: element count register, transaction accept and classification.
module afps_front
   import afps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [COUNT_BITS-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [INDEX_BITS-1:0] req_entry_index,
   input  logic [VALUE_BITS-1:0] req_new_value,
   input  logic                  queue_full,
   output logic                  push,
   output queue_item_type        push_item
);

   logic [COUNT_BITS-1:0] element_count_ff;
   logic [COUNT_BITS-1:0] element_count_in;
   logic [COUNT_BITS-1:0] count_eff;

   always_comb begin
      element_count_in = csr_write_enable ? csr_write_data : element_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= COUNT_RESET;
      end else begin
         element_count_ff <= element_count_in;
      end
   end

   // cap the count at the table depth
   assign count_eff = (element_count_ff > COUNT_CAP) ? COUNT_CAP : element_count_ff;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.cmd = cmd_type'(req_command);
      push_item.idx = req_entry_index;
      push_item.val = req_new_value;
      push_item.cnt = count_eff;
      push_item.err = (push_item.cmd == CMD_WRITE) &&
                      (COUNT_BITS'(req_entry_index) >= count_eff);
   end

endmodule

@@ sv/afps_queue.sv @@
// Short queue of classified transactions between front and back.
module afps_queue
   import afps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  queue_item_type push_item,
   output logic           full,
   input  logic           pop,
   output logic           empty,
   output queue_item_type head_item
);

   queue_item_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff;
   logic [QPTR_BITS-1:0]  wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff;
   logic [QPTR_BITS-1:0]  rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff;
   logic [QCNT_BITS-1:0]  count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ sv/afps_back.sv @@
// Back end: entry memory read-modify-write, running total and result register.
module afps_back
   import afps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  queue_item_type        head_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SUM_BITS-1:0]   rsp_total_sum,
   output logic                  rsp_index_error
);

   back_state_type          state_ff;
   back_state_type          state_in;

   mem_entry_type           entry_ram_ff [MAX_ENTRIES];
   mem_entry_type           rd_ff;

   queue_item_type          item_ff;
   logic [TOTAL_BITS-1:0]   calc_ff;
   logic [TOTAL_BITS-1:0]   calc_in;
   logic [TOTAL_BITS-1:0]   total_ff;
   logic [VALUE_BITS-1:0]   fill_value_ff;
   logic [EPOCH_BITS-1:0]   epoch_ff;
   logic [INDEX_BITS-1:0]   clear_addr_ff;

   logic                    rsp_valid_ff;
   logic [SUM_BITS-1:0]     rsp_total_ff;
   logic                    rsp_err_ff;

   logic                    out_free;
   logic                    commit;
   logic                    clear_we;
   logic                    mem_we;
   logic [INDEX_BITS-1:0]   mem_wr_addr;
   mem_entry_type           mem_wr_data;
   logic [VALUE_BITS-1:0]   old_value;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      commit   = 1'b0;
      clear_we = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               state_in = BK_CALC;
            end
         end
         BK_CALC: begin
            state_in = BK_COMMIT;
         end
         BK_COMMIT: begin
            if (out_free) begin
               commit = 1'b1;
               if (item_ff.cmd == CMD_FILL && epoch_ff == EPOCH_LAST) begin
                  state_in = BK_CLEAR;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_CLEAR: begin
            clear_we = 1'b1;
            if (clear_addr_ff == INDEX_LAST) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // an entry is valid only when its tag matches the current epoch
   assign old_value = (rd_ff.tag == epoch_ff) ? rd_ff.value : fill_value_ff;

   always_comb begin
      if (item_ff.cmd == CMD_FILL) begin
         calc_in = TOTAL_BITS'(item_ff.val) * TOTAL_BITS'(item_ff.cnt);
      end else if (item_ff.err) begin
         calc_in = total_ff;
      end else begin
         calc_in = total_ff + TOTAL_BITS'(item_ff.val) - TOTAL_BITS'(old_value);
      end
   end

   assign mem_we      = clear_we || (commit && item_ff.cmd == CMD_WRITE && !item_ff.err);
   assign mem_wr_addr = clear_we ? clear_addr_ff : item_ff.idx;

   always_comb begin
      if (clear_we) begin
         mem_wr_data.tag   = EPOCH_NONE;
         mem_wr_data.value = '0;
      end else begin
         mem_wr_data.tag   = epoch_ff;
         mem_wr_data.value = item_ff.val;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_ram_ff[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= entry_ram_ff[head_item.idx];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head_item;
      end
      if (state_ff == BK_CALC) begin
         calc_ff <= calc_in;
      end
      if (commit) begin
         rsp_total_ff <= calc_ff[SUM_BITS-1:0];
         rsp_err_ff   <= item_ff.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         fill_value_ff <= '0;
         epoch_ff      <= EPOCH_FIRST;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (commit) begin
            total_ff     <= calc_ff;
            rsp_valid_ff <= 1'b1;
            if (item_ff.cmd == CMD_FILL) begin
               fill_value_ff <= item_ff.val;
               epoch_ff      <= (epoch_ff == EPOCH_LAST) ? EPOCH_FIRST
                                                         : epoch_ff + EPOCH_BITS'(1);
               clear_addr_ff <= '0;
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (clear_we) begin
            clear_addr_ff <= clear_addr_ff + INDEX_BITS'(1);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_total_sum   = rsp_total_ff;
   assign rsp_index_error = rsp_err_ff;

`ifndef SYNTHESIS
   a_no_pop_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> !pop
   ) else $error("transaction popped during memory clear");

   a_epoch_never_none: assert property (
      @(posedge clock) disable iff (reset)
      epoch_ff != EPOCH_NONE
   ) else $error("epoch reached the cleared-entry tag");

   a_error_no_write: assert property (
      @(posedge clock) disable iff (reset)
      (mem_we && !clear_we) |-> (!item_ff.err && item_ff.cmd == CMD_WRITE)
   ) else $error("memory written by a fill or an out-of-range write");

   a_commit_needs_free_output: assert property (
      @(posedge clock) disable iff (reset)
      commit |-> (!rsp_valid_ff || !rsp_stall)
   ) else $error("result overwritten while still held");
`endif

endmodule

@@ sim/array_fill_and_point_write_sum_top_tb.sv @@
// Testbench for the table with lazy global fill and running sum of entries.
module array_fill_and_point_write_sum_top_tb;
   import afps_pkg::*;

   // Leave room for a tag clearing pass after reset or after an epoch wrap.
   localparam int CLEAR_PASS_CYCLES = 1100;
   // Cycles to watch for stray results once everything has come back.
   localparam int TAIL_CYCLES       = 16;
   localparam int TIMEOUT_UNITS     = 2000000;

   // One request transaction as queued for the driver.
   typedef struct {
      cmd_type               op;
      logic [INDEX_BITS-1:0] slot;
      logic [VALUE_BITS-1:0] value;
      bit                    drain_first;   // hold until every result is back
   } sum_op_type;

   // One response transaction as it should come back.
   typedef struct {
      logic [SUM_BITS-1:0] total;
      logic                index_error;
   } total_word_type;

   // DUT ports, every input known from time zero.
   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [COUNT_BITS-1:0] csr_write_data   = '0;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic                  req_command      = 1'b0;
   logic [INDEX_BITS-1:0] req_entry_index  = '0;
   logic [VALUE_BITS-1:0] req_new_value    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [SUM_BITS-1:0]   rsp_total_sum;
   logic                  rsp_index_error;

   // Shadow state of the table, updated at every accepted request.
   logic [VALUE_BITS-1:0] entry_val [MAX_ENTRIES];
   bit                    entry_marked [MAX_ENTRIES];
   logic [VALUE_BITS-1:0] fill_val;
   logic [TOTAL_BITS-1:0] running;
   logic [COUNT_BITS-1:0] count_reg;

   sum_op_type     ops_to_send [$];
   total_word_type totals_due [$];
   sum_op_type     cur_op;
   int             mismatch_count = 0;
   int             result_seq     = 0;

   // Driver and monitor pacing.
   int send_gap      = 0;
   int send_steady   = 0;
   int stall_left    = 0;
   int stall_steady  = 0;

   array_fill_and_point_write_sum_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_entry_index  (req_entry_index),
      .req_new_value    (req_new_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_total_sum    (rsp_total_sum),
      .rsp_index_error  (rsp_index_error)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Advance the shadow table by one transaction and return the response it owes.
   function automatic total_word_type advance_running_total(sum_op_type item);
      total_word_type        word;
      logic [COUNT_BITS-1:0] span;
      logic [VALUE_BITS-1:0] prior;
      // The count register is capped at the table depth.
      span = (count_reg > COUNT_CAP) ? COUNT_CAP : count_reg;
      word.index_error = 1'b0;
      if (item.op == CMD_FILL) begin
         fill_val = item.value;
         for (int i = 0; i < MAX_ENTRIES; i++) entry_marked[i] = 1'b0;
         running = TOTAL_BITS'(item.value) * TOTAL_BITS'(span);
      end else if (COUNT_BITS'(item.slot) >= span) begin
         // Out-of-range write: nothing moves, flag it.
         word.index_error = 1'b1;
      end else begin
         // An unmarked entry still holds the fill value.
         prior = entry_marked[item.slot] ? entry_val[item.slot] : fill_val;
         running = running + TOTAL_BITS'(item.value) - TOTAL_BITS'(prior);
         entry_val[item.slot]    = item.value;
         entry_marked[item.slot] = 1'b1;
      end
      word.total = running[SUM_BITS-1:0];
      return word;
   endfunction

   task automatic note_mismatch(input string what);
      $display("ERROR at %0t, response %0d: %s", $time, result_seq, what);
      mismatch_count++;
   endtask

   task automatic queue_op(input cmd_type op, input logic [INDEX_BITS-1:0] slot,
                           input logic [VALUE_BITS-1:0] value, input bit drain_first);
      sum_op_type item;
      item.op          = op;
      item.slot        = slot;
      item.value       = value;
      item.drain_first = drain_first;
      ops_to_send.insert(ops_to_send.size(), item);
   endtask

   // Queue random transactions shaped for the given element count.
   task automatic queue_random_ops(input int n, input int count);
      int                    span;
      int                    pick;
      int                    hot;
      cmd_type               op;
      logic [INDEX_BITS-1:0] slot;
      logic [VALUE_BITS-1:0] value;
      span = (count > MAX_ENTRIES) ? MAX_ENTRIES : count;
      hot  = (span < 8) ? span : 8;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         // Mostly in-range writes; a hot set keeps hitting marked entries.
         if (pick < 10 || span == 0)
            slot = INDEX_BITS'($urandom_range(0, MAX_ENTRIES - 1));
         else if (pick < 20 && span < MAX_ENTRIES)
            slot = INDEX_BITS'($urandom_range(span, MAX_ENTRIES - 1));
         else if (pick < 50)
            slot = INDEX_BITS'($urandom_range(0, hot - 1));
         else
            slot = INDEX_BITS'($urandom_range(0, span - 1));
         // Fills often enough to wrap the epoch counter at least once.
         op = ($urandom_range(0, 3) == 0) ? CMD_FILL : CMD_WRITE;
         pick = $urandom_range(0, 9);
         if (pick == 0)
            value = '1;
         else if (pick == 1)
            value = '0;
         else
            value = VALUE_BITS'($urandom());
         queue_op(op, slot, value, $urandom_range(0, 49) == 0);
      end
   endtask

   // Hold until every queued transaction is sent and every response is back.
   task automatic wait_for_drain();
      while (ops_to_send.size() != 0 || req_valid || totals_due.size() != 0)
         @(posedge clock);
   endtask

   // Write the count only with the block idle, after any clearing pass.
   task automatic write_element_count(input logic [COUNT_BITS-1:0] count);
      wait_for_drain();
      repeat (CLEAR_PASS_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= count;
      count_reg = count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Request driver: one transaction at a time, random gaps drawn per transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         send_gap    = 0;
         send_steady = 0;
      end else begin
         // Predict at acceptance so the shadow state follows the DUT's order.
         if (req_valid && !req_stall)
            totals_due.insert(totals_due.size(), advance_running_total(cur_op));
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (ops_to_send.size() != 0 &&
                         !(ops_to_send[0].drain_first && totals_due.size() != 0)) begin
               cur_op = ops_to_send.pop_front();
               req_valid       <= 1'b1;
               req_command     <= cur_op.op;
               req_entry_index <= cur_op.slot;
               req_new_value   <= cur_op.value;
               // Draw the wait before the next transaction; drop gaps in steady runs.
               if (send_steady > 0) begin
                  send_steady--;
                  send_gap = 0;
               end else if ($urandom_range(0, 15) == 0) begin
                  send_steady = $urandom_range(16, 48);
                  send_gap    = 0;
               end else begin
                  send_gap = $urandom_range(0, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted response, stall a random count per response.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         stall_left   = 0;
         stall_steady = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_seq++;
            if (totals_due.size() == 0) begin
               note_mismatch($sformatf("response with none outstanding, total %h",
                                       rsp_total_sum));
            end else begin
               total_word_type want;
               want = totals_due.pop_front();
               if (rsp_total_sum !== want.total)
                  note_mismatch($sformatf("total_sum %h, predicted %h",
                                          rsp_total_sum, want.total));
               if (rsp_index_error !== want.index_error)
                  note_mismatch($sformatf("index_error %b, predicted %b",
                                          rsp_index_error, want.index_error));
            end
            if (stall_steady > 0) begin
               stall_steady--;
               stall_left = 0;
            end else if ($urandom_range(0, 15) == 0) begin
               stall_steady = $urandom_range(16, 48);
               stall_left   = 0;
            end else begin
               stall_left = $urandom_range(0, 6);
            end
         end else if (rsp_valid && stall_left > 0) begin
            // Count stall cycles only while a response waits.
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // Stimulus: directed corners, then random phases under several counts.
   initial begin
      for (int i = 0; i < MAX_ENTRIES; i++) entry_marked[i] = 1'b0;
      fill_val  = '0;
      running   = '0;
      count_reg = COUNT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Full table: extreme values at both ends, overwrite of a marked entry,
      // write over a fill, and a pause until the pipe is empty.
      write_element_count(COUNT_CAP);
      queue_op(CMD_WRITE, '0, '1, 1'b0);
      queue_op(CMD_WRITE, INDEX_LAST, '1, 1'b0);
      queue_op(CMD_WRITE, INDEX_LAST, '0, 1'b0);
      queue_op(CMD_FILL, '0, '1, 1'b1);
      queue_op(CMD_WRITE, INDEX_LAST, '0, 1'b0);
      queue_op(CMD_WRITE, '0, VALUE_BITS'(1), 1'b0);
      queue_op(CMD_FILL, INDEX_LAST, '0, 1'b0);

      // Zero count: fill gives a zero total, every write is an index error.
      write_element_count('0);
      queue_op(CMD_FILL, '0, '1, 1'b0);
      queue_op(CMD_WRITE, '0, VALUE_BITS'(5), 1'b0);

      // Count above the table depth, changed since the last fill: the total
      // is not rebuilt, so a write of zero over the fill value wraps it.
      write_element_count('1);
      queue_op(CMD_WRITE, '0, '0, 1'b0);
      queue_op(CMD_WRITE, INDEX_LAST, VALUE_BITS'(30'h2AAAAAAA), 1'b0);
      queue_op(CMD_FILL, '0, VALUE_BITS'(30'h15555555), 1'b0);
      queue_op(CMD_WRITE, INDEX_BITS'(512), '1, 1'b0);

      // Single entry: only index zero is in range.
      write_element_count(COUNT_BITS'(1));
      queue_op(CMD_WRITE, '0, VALUE_BITS'(7), 1'b0);
      queue_op(CMD_WRITE, INDEX_BITS'(1), VALUE_BITS'(9), 1'b0);
      queue_op(CMD_WRITE, INDEX_LAST, VALUE_BITS'(1), 1'b0);
      queue_op(CMD_FILL, INDEX_BITS'(1), '1, 1'b0);

      // Random phases.
      write_element_count(COUNT_CAP);
      queue_random_ops(260, MAX_ENTRIES);
      write_element_count(COUNT_BITS'($urandom_range(2, MAX_ENTRIES - 1)));
      queue_random_ops(260, count_reg);
      write_element_count(COUNT_BITS'(8));
      queue_random_ops(200, count_reg);
      write_element_count(COUNT_BITS'($urandom_range(MAX_ENTRIES + 1, 2047)));
      queue_random_ops(200, count_reg);
      write_element_count(COUNT_BITS'(3));
      queue_random_ops(100, count_reg);
      write_element_count(COUNT_CAP);
      queue_random_ops(310, MAX_ENTRIES);

      // Drain, then watch a little longer for stray responses.
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Bound the run in case the DUT hangs.
   initial begin
      #TIMEOUT_UNITS;
      $display("Mismatches found");
      $finish;
   end

endmodule
